>>> sv/scoi_pkg.sv
// Shared widths, sequencer state codes and control structs for the overlap integral block.
`timescale 1ns / 1ps

package scoi_pkg;

    localparam int DATA_W    = 24;
    localparam int SUM_W     = 48;
    localparam int STEP_W    = 20;
    localparam int MUL_W     = 32;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int M_W       = STEP_W + 2;
    localparam int PMAG_W    = 2 * DATA_W;
    localparam int P_W       = PMAG_W + 1;
    localparam int TERM_W    = SUM_W + 2;
    localparam int ACC_EXT_W = SUM_W + 3;

    // Simpson weight as a left shift of step_third
    localparam int WSH_ODD  = 2;
    localparam int WSH_EVEN = 1;

    // weighting: term = round(t * m / 2^B_SHIFT) built from two 32-bit halves of t
    localparam int B_SHIFT     = 20;
    localparam int A_SHIFT     = MUL_W - B_SHIFT;
    localparam int A_CLAMP_BIT = SUM_W + 1 - A_SHIFT;

    typedef enum logic [17:0] {
        S_IDLE = 18'h00001,
        S_PW0  = 18'h00002,
        S_PW1  = 18'h00004,
        S_PW2  = 18'h00008,
        S_PW3  = 18'h00010,
        S_PSUM = 18'h00020,
        S_QRND = 18'h00040,
        S_TRL  = 18'h00080,
        S_TRH  = 18'h00100,
        S_TIL  = 18'h00200,
        S_TIH  = 18'h00400,
        S_WRA  = 18'h00800,
        S_WRB  = 18'h01000,
        S_WIA  = 18'h02000,
        S_WIB  = 18'h04000,
        S_WFIN = 18'h08000,
        S_ACCI = 18'h10000,
        S_DONE = 18'h20000
    } t_state;

    typedef struct packed {
        t_state step;
        logic   load;
        logic   odd;
        logic   emit;
    } t_dp_cmd;

    typedef struct packed {
        logic last;
    } t_dp_stat;

endpackage

>>> sv/scoi_if.sv
// Request channel interfaces: grid point input, integral output and configuration write.
`timescale 1ns / 1ps

interface scoi_in_if import scoi_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] wave_re;
    logic signed [DATA_W-1:0] wave_im;
    logic signed [DATA_W-1:0] form_re;
    logic signed [DATA_W-1:0] form_im;
    logic signed [DATA_W-1:0] bound_wave;
    logic                     last_point;

    modport source (output valid, wave_re, wave_im, form_re, form_im, bound_wave, last_point,
                    input ready);
    modport sink   (input valid, wave_re, wave_im, form_re, form_im, bound_wave, last_point,
                    output ready);
endinterface

interface scoi_out_if import scoi_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [SUM_W-1:0] sum_re;
    logic signed [SUM_W-1:0] sum_im;
    logic                    overflow;

    modport source (output valid, sum_re, sum_im, overflow, input ready);
    modport sink   (input valid, sum_re, sum_im, overflow, output ready);
endinterface

interface scoi_cfg_if import scoi_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [STEP_W-1:0] step_third;

    modport source (output valid, step_third, input ready);
    modport sink   (input valid, step_third, output ready);
endinterface

>>> sv/scoi_ctrl.sv
// Sequencer for the overlap integral: steps one grid point through the shared multiplier.
`timescale 1ns / 1ps

module scoi_ctrl import scoi_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state, n_state;
    logic   r_odd, n_odd;
    logic   r_out_valid, n_out_valid;
    logic   accept;
    logic   emit;

    assign o_in_ready  = (r_state == S_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign emit        = (r_state == S_DONE) && i_stat.last && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_PW0;
                end
            end
            S_PW0:  n_state = S_PW1;
            S_PW1:  n_state = S_PW2;
            S_PW2:  n_state = S_PW3;
            S_PW3:  n_state = S_PSUM;
            S_PSUM: n_state = S_QRND;
            S_QRND: n_state = S_TRL;
            S_TRL:  n_state = S_TRH;
            S_TRH:  n_state = S_TIL;
            S_TIL:  n_state = S_TIH;
            S_TIH:  n_state = S_WRA;
            S_WRA:  n_state = S_WRB;
            S_WRB:  n_state = S_WIA;
            S_WIA:  n_state = S_WIB;
            S_WIB:  n_state = S_WFIN;
            S_WFIN: n_state = S_ACCI;
            S_ACCI: n_state = S_DONE;
            S_DONE: begin
                if (!i_stat.last || emit) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_odd = r_odd;
        if (r_state == S_DONE) begin
            if (!i_stat.last) begin
                n_odd = !r_odd;
            end else if (emit) begin
                n_odd = 1'b1;
            end
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_odd       <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_odd       <= n_odd;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        o_cmd.step = r_state;
        o_cmd.load = accept;
        o_cmd.odd  = r_odd;
        o_cmd.emit = emit;
    end

endmodule

>>> sv/scoi_dp.sv
// Datapath: shared 32x32 multiplier, complex product, rounding, Simpson weighting, accumulators.
`timescale 1ns / 1ps

module scoi_dp import scoi_pkg::*; #(
    parameter int SAMPLE_FRAC_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dp_cmd                  i_cmd,
    output t_dp_stat                 o_stat,
    input  logic                     i_cfg_valid,
    input  logic [STEP_W-1:0]        i_step_third,
    input  logic signed [DATA_W-1:0] i_wave_re,
    input  logic signed [DATA_W-1:0] i_wave_im,
    input  logic signed [DATA_W-1:0] i_form_re,
    input  logic signed [DATA_W-1:0] i_form_im,
    input  logic signed [DATA_W-1:0] i_bound_wave,
    input  logic                     i_last_point,
    output logic signed [SUM_W-1:0]  o_sum_re,
    output logic signed [SUM_W-1:0]  o_sum_im,
    output logic                     o_overflow
);

    localparam int QMAG_W = PMAG_W - SAMPLE_FRAC_BITS;
    localparam int TMAG_W = QMAG_W + DATA_W - 1;
    localparam logic [TERM_W-1:0] TERM_CLAMP = TERM_W'(1) << SUM_W;

    typedef struct packed {
        logic [SUM_W-1:0] val;
        logic             sat;
    } t_sat_res;

    function automatic logic [DATA_W-1:0] mag(input logic [DATA_W-1:0] x);
        return x[DATA_W-1] ? -x : x;
    endfunction

    // round half away from zero of p / 2^F, magnitude only
    function automatic logic [QMAG_W-1:0] round_q(input logic [P_W-1:0] p);
        logic [P_W-1:0]    pabs;
        logic [PMAG_W-1:0] psum;
        pabs = p[P_W-1] ? -p : p;
        psum = pabs[PMAG_W-1:0] + (PMAG_W'(1) << (SAMPLE_FRAC_BITS - 1));
        return QMAG_W'(psum >> SAMPLE_FRAC_BITS);
    endfunction

    // a: upper half of |t| times m, b: lower half of |t| times m
    function automatic logic [TERM_W-1:0] weigh(input logic [PROD_W-1:0] a,
                                                input logic [PROD_W-1:0] b,
                                                input logic neg);
        logic [PROD_W-1:0] bround;
        logic [TERM_W-1:0] res;
        logic [TERM_W-1:0] tmag;
        bround = b + (PROD_W'(1) << (B_SHIFT - 1));
        res    = TERM_W'({a[A_CLAMP_BIT-1:0], {A_SHIFT{1'b0}}}) + TERM_W'(bround >> B_SHIFT);
        if ((|a[PROD_W-1:A_CLAMP_BIT]) || (res > TERM_CLAMP)) begin
            tmag = TERM_CLAMP;
        end else begin
            tmag = res;
        end
        return neg ? -tmag : tmag;
    endfunction

    function automatic t_sat_res sat_add(input logic [SUM_W-1:0] acc,
                                         input logic [TERM_W-1:0] term);
        logic [ACC_EXT_W-1:0] s;
        logic [3:0]           hi;
        t_sat_res             r;
        s  = {{(ACC_EXT_W - SUM_W){acc[SUM_W-1]}}, acc} + {term[TERM_W-1], term};
        hi = s[ACC_EXT_W-1:SUM_W-1];
        r.sat = (hi != 4'b0000) && (hi != 4'b1111);
        if (!r.sat) begin
            r.val = s[SUM_W-1:0];
        end else if (s[ACC_EXT_W-1]) begin
            r.val = {1'b1, {(SUM_W - 1){1'b0}}};
        end else begin
            r.val = {1'b0, {(SUM_W - 1){1'b1}}};
        end
        return r;
    endfunction

    logic [STEP_W-1:0] r_step;
    logic [DATA_W-1:0] r_wr, r_wi, r_fr, r_fi, r_bw;
    logic              r_last;
    logic [M_W-1:0]    r_m;
    logic [PROD_W-1:0] r_prod;
    logic              r_pneg;
    logic [P_W-1:0]    r_p_re, r_p_im;
    logic [QMAG_W-1:0] r_qmag_re, r_qmag_im;
    logic              r_tneg_re, r_tneg_im;
    logic [TMAG_W-1:0] r_tmag_re, r_tmag_im;
    logic [PROD_W-1:0] r_a;
    logic [TERM_W-1:0] r_term_re, r_term_im;
    logic [SUM_W-1:0]  r_acc_re, r_acc_im;
    logic              r_sat;
    logic [SUM_W-1:0]  r_sum_re, r_sum_im;
    logic              r_ovf;

    logic [MUL_W-1:0]  mul_a, mul_b;
    logic              mul_neg;
    logic [PROD_W-1:0] q_re_ext, q_im_ext, t_re_ext, t_im_ext;
    logic [MUL_W-1:0]  bw_ext, m_ext;
    logic [P_W-1:0]    prod_p, pterm;
    logic [TMAG_W-1:0] prod_lo, prod_hi;
    logic [1:0]        wsh;
    t_sat_res          add_re, add_im;

    assign q_re_ext = PROD_W'(r_qmag_re);
    assign q_im_ext = PROD_W'(r_qmag_im);
    assign t_re_ext = PROD_W'(r_tmag_re);
    assign t_im_ext = PROD_W'(r_tmag_im);
    assign bw_ext   = MUL_W'(mag(r_bw));
    assign m_ext    = MUL_W'(r_m);
    assign prod_p   = r_prod[P_W-1:0];
    assign pterm    = r_pneg ? -prod_p : prod_p;
    assign prod_lo  = TMAG_W'(r_prod);
    assign prod_hi  = TMAG_W'({r_prod[MUL_W-1:0], {MUL_W{1'b0}}});
    assign add_re   = sat_add(r_acc_re, r_term_re);
    assign add_im   = sat_add(r_acc_im, r_term_im);
    assign wsh      = i_last_point ? 2'd0 : (i_cmd.odd ? 2'(WSH_ODD) : 2'(WSH_EVEN));

    always_comb begin
        mul_a   = '0;
        mul_b   = '0;
        mul_neg = 1'b0;
        case (i_cmd.step)
            S_PW0: begin
                mul_a   = MUL_W'(mag(r_wr));
                mul_b   = MUL_W'(mag(r_fr));
                mul_neg = r_wr[DATA_W-1] ^ r_fr[DATA_W-1];
            end
            S_PW1: begin
                mul_a   = MUL_W'(mag(r_wi));
                mul_b   = MUL_W'(mag(r_fi));
                mul_neg = r_wi[DATA_W-1] ^ r_fi[DATA_W-1];
            end
            S_PW2: begin
                mul_a   = MUL_W'(mag(r_wr));
                mul_b   = MUL_W'(mag(r_fi));
                mul_neg = r_wr[DATA_W-1] ^ r_fi[DATA_W-1];
            end
            S_PW3: begin
                mul_a   = MUL_W'(mag(r_wi));
                mul_b   = MUL_W'(mag(r_fr));
                mul_neg = r_wi[DATA_W-1] ^ r_fr[DATA_W-1];
            end
            S_TRL: begin
                mul_a = q_re_ext[MUL_W-1:0];
                mul_b = bw_ext;
            end
            S_TRH: begin
                mul_a = q_re_ext[PROD_W-1:MUL_W];
                mul_b = bw_ext;
            end
            S_TIL: begin
                mul_a = q_im_ext[MUL_W-1:0];
                mul_b = bw_ext;
            end
            S_TIH: begin
                mul_a = q_im_ext[PROD_W-1:MUL_W];
                mul_b = bw_ext;
            end
            S_WRA: begin
                mul_a = t_re_ext[PROD_W-1:MUL_W];
                mul_b = m_ext;
            end
            S_WRB: begin
                mul_a = t_re_ext[MUL_W-1:0];
                mul_b = m_ext;
            end
            S_WIA: begin
                mul_a = t_im_ext[PROD_W-1:MUL_W];
                mul_b = m_ext;
            end
            S_WIB: begin
                mul_a = t_im_ext[MUL_W-1:0];
                mul_b = m_ext;
            end
            default: begin
                mul_a   = '0;
                mul_b   = '0;
                mul_neg = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        r_pneg <= mul_neg;

        if (i_cmd.load) begin
            r_wr   <= i_wave_re;
            r_wi   <= i_wave_im;
            r_fr   <= i_form_re;
            r_fi   <= i_form_im;
            r_bw   <= i_bound_wave;
            r_last <= i_last_point;
            r_m    <= M_W'(r_step) << wsh;
        end

        case (i_cmd.step)
            S_PW1:  r_p_re <= pterm;
            S_PW2:  r_p_re <= r_p_re - pterm;
            S_PW3:  r_p_im <= pterm;
            S_PSUM: r_p_im <= r_p_im + pterm;
            S_QRND: begin
                r_qmag_re <= round_q(r_p_re);
                r_qmag_im <= round_q(r_p_im);
                r_tneg_re <= r_p_re[P_W-1] ^ r_bw[DATA_W-1];
                r_tneg_im <= r_p_im[P_W-1] ^ r_bw[DATA_W-1];
            end
            S_TRH:  r_tmag_re <= prod_lo;
            S_TIL:  r_tmag_re <= r_tmag_re + prod_hi;
            S_TIH:  r_tmag_im <= prod_lo;
            S_WRA:  r_tmag_im <= r_tmag_im + prod_hi;
            S_WRB:  r_a       <= r_prod;
            S_WIA:  r_term_re <= weigh(r_a, r_prod, r_tneg_re);
            S_WIB:  r_a       <= r_prod;
            S_WFIN: r_term_im <= weigh(r_a, r_prod, r_tneg_im);
            default: begin
            end
        endcase

        if (i_cmd.emit) begin
            r_sum_re <= r_acc_re;
            r_sum_im <= r_acc_im;
            r_ovf    <= r_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step   <= '0;
            r_acc_re <= '0;
            r_acc_im <= '0;
            r_sat    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_step <= i_step_third;
            end
            if (i_cmd.emit) begin
                r_acc_re <= '0;
                r_acc_im <= '0;
                r_sat    <= 1'b0;
            end else if (i_cmd.step == S_WIB) begin
                r_acc_re <= add_re.val;
                r_sat    <= r_sat | add_re.sat;
            end else if (i_cmd.step == S_ACCI) begin
                r_acc_im <= add_im.val;
                r_sat    <= r_sat | add_im.sat;
            end
        end
    end

    assign o_stat.last = r_last;
    assign o_sum_re    = r_sum_re;
    assign o_sum_im    = r_sum_im;
    assign o_overflow  = r_ovf;

endmodule

>>> sv/simpson_complex_overlap_integral.sv
// A result becomes valid in the output register once the last grid point has run through
// the 16-step sequence through the single shared 32x32 multiplier and the finish state,
// which waits while an earlier result is untaken. A point is accepted only when idle.
// A finished integral waits in the output register while the next point runs.
// Reset (synchronous, active low) clears the accumulators, overflow flag,
// step_third and output valid, and sets the odd-point phase.
`timescale 1ns / 1ps

module simpson_complex_overlap_integral import scoi_pkg::*; #(
    parameter int SAMPLE_FRAC_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    scoi_cfg_if.sink   i_cfg,
    scoi_in_if.sink    i_in,
    scoi_out_if.source o_out
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;
    logic     w_in_ready;
    logic     w_out_valid;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = w_in_ready;
    assign o_out.valid = w_out_valid;

    scoi_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_out.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    scoi_dp #(
        .SAMPLE_FRAC_BITS (SAMPLE_FRAC_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_cfg_valid  (i_cfg.valid),
        .i_step_third (i_cfg.step_third),
        .i_wave_re    (i_in.wave_re),
        .i_wave_im    (i_in.wave_im),
        .i_form_re    (i_in.form_re),
        .i_form_im    (i_in.form_im),
        .i_bound_wave (i_in.bound_wave),
        .i_last_point (i_in.last_point),
        .o_sum_re     (o_out.sum_re),
        .o_sum_im     (o_out.sum_im),
        .o_overflow   (o_out.overflow)
    );

endmodule

>>> sv/scoi_checker.sv
// Port-level checks for the overlap integral block, bound to the top level.
`timescale 1ns / 1ps

module scoi_checker import scoi_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    i_in_ready,
    input logic                    i_out_valid,
    input logic                    i_out_ready,
    input logic signed [SUM_W-1:0] i_sum_re,
    input logic signed [SUM_W-1:0] i_sum_im,
    input logic                    i_overflow
);

    // a stalled result request holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_sum_re) && $stable(i_sum_im) && $stable(i_overflow))
        else $error("result request changed while stalled");

    // one point in flight: busy for the following cycles
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready ##1 !i_in_ready)
        else $error("input taken while a point is in flight");

    // a result appears only at the end of a point's sequence
    a_emit_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(!i_in_ready))
        else $error("result appeared while idle");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind simpson_complex_overlap_integral scoi_checker u_scoi_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_sum_re    (o_out.sum_re),
    .i_sum_im    (o_out.sum_im),
    .i_overflow  (o_out.overflow)
);
